[src/gas_pkg.sv]
// Shared constants and helpers for the grid A* path search block.
package gas_pkg;

    localparam int DEF_GRID_WIDTH  = 16;
    localparam int DEF_GRID_HEIGHT = 16;

    localparam int COST_W = 18;
    localparam logic [COST_W-1:0] COST_INF      = 18'h3FFFF;
    localparam logic [COST_W-1:0] STEP_STRAIGHT = 18'd256;
    localparam logic [COST_W-1:0] STEP_DIAG     = 18'd362;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_PAST    = 2'd2;

    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    localparam int PLEN_MAX = 511;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, COST_INF}) ? COST_INF : s[COST_W-1:0];
    endfunction

endpackage

[src/grid_astar_path_search.sv]
// Top level of the grid A* path search: sequencer, square-root unit and three RAMs.
//
// One input word carries a mode. Mode 0 writes one obstacle cell, mode 1 runs a
// search from start_cell to goal_cell, mode 2 returns the next cell of the stored
// path (start first). Every accepted word gives exactly one result word.
// Both channels use valid/stall; o_stall is low only while the sequencer idles.
// Results sit in an output register; a stalled result holds, and the block can
// take the next input word meanwhile, finishing it when the register frees.
// Obstacle writes and other modes go straight to the result; path reads first read
// the path RAM. A search splits the cell indices into rows and columns, clears the
// node RAM, checks and seeds the start cell, then per expanded cell scans the node
// RAM, picks the best open cell and updates up to 8 neighbors, running the 16-step
// square-root unit when a cost improves, and at the end walks the path back from the
// goal; the node RAM has a single read port. After reset the obstacle RAM is cleared,
// one cell per cycle, before the first input word is taken.
module grid_astar_path_search #(
    parameter int GRID_WIDTH  = gas_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = gas_pkg::DEF_GRID_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_cell_index,
    input  logic       i_blocked,
    input  logic [7:0] i_start_cell,
    input  logic [7:0] i_goal_cell,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [8:0] o_path_length,
    output logic [3:0] o_cell_column,
    output logic [3:0] o_cell_row,
    output logic       o_last_cell
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_HEIGHT);
    localparam int CLW   = $clog2(GRID_WIDTH);
    localparam int PW    = RW + CLW;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int DW    = (RW > CLW) ? RW : CLW;
    localparam int CSW   = gas_pkg::COST_W;

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_CLR   = 5'd3;
    localparam logic [4:0] S_CHK   = 5'd4;
    localparam logic [4:0] S_SQL   = 5'd5;
    localparam logic [4:0] S_SQ    = 5'd6;
    localparam logic [4:0] S_SEED  = 5'd7;
    localparam logic [4:0] S_SCAN  = 5'd8;
    localparam logic [4:0] S_PICK  = 5'd9;
    localparam logic [4:0] S_NB    = 5'd10;
    localparam logic [4:0] S_NBCHK = 5'd11;
    localparam logic [4:0] S_NBWR  = 5'd12;
    localparam logic [4:0] S_NEXT  = 5'd13;
    localparam logic [4:0] S_TB    = 5'd14;
    localparam logic [4:0] S_TBRD  = 5'd15;
    localparam logic [4:0] S_PRD   = 5'd16;
    localparam logic [4:0] S_EMIT  = 5'd17;

    typedef struct packed {
        logic           is_open;
        logic           is_closed;
        logic [PW-1:0]  parent;
        logic [CSW-1:0] score;
        logic [CSW-1:0] cost;
    } t_node;

    function automatic logic [IW-1:0] addr_of(input logic [RW-1:0] r,
                                              input logic [CLW-1:0] c);
        return IW'(int'(r) * GRID_WIDTH + int'(c));
    endfunction

    function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [4:0]     r_state;
    logic [4:0]     r_sq_ret;
    logic [IW-1:0]  r_cnt;
    logic [7:0]     r_sidx, r_gidx;
    logic [RW-1:0]  r_srow, r_grow;
    logic [RW-1:0]  r_crow, r_prow, r_brow, r_nrow, r_cur_row;
    logic [CLW-1:0] r_ccol, r_pcol, r_bcol, r_ncol, r_cur_col;
    logic [IW-1:0]  r_pidx, r_baddr, r_naddr;
    logic           r_pv, r_sdone, r_have, r_upd, r_diag;
    t_node          r_best, r_nw, n_nw;
    logic [2:0]     r_k;
    logic [DW-1:0]  r_dx, r_dy;
    logic [31:0]    r_sq_v, r_sq_res;
    logic [3:0]     r_sq_k;
    logic [CW-1:0]  r_len, r_pc, r_rp;
    logic [1:0]     r_res_status;
    logic [8:0]     r_res_len;
    logic [3:0]     r_res_col, r_res_row;
    logic           r_res_last;
    logic           r_o_valid;
    logic [1:0]     r_o_status;
    logic [8:0]     r_o_len;
    logic [3:0]     r_o_col, r_o_row;
    logic           r_o_last;

    logic           obs_we, obs_wdata, obs_rdata;
    logic [IW-1:0]  obs_waddr, obs_raddr;
    logic           sm_we;
    logic [IW-1:0]  sm_waddr, sm_raddr;
    t_node          sm_wdata, sm_rdata;
    logic           pth_we;
    logic [IW-1:0]  pth_waddr, pth_raddr;
    logic [PW-1:0]  pth_wdata, pth_rdata;

    logic           accept;
    logic           out_load;
    logic           start_in, goal_in, cell_in;
    logic [1:0]     nb_dr, nb_dc;
    logic           nb_in, nb_diag;
    logic [RW-1:0]  nb_row;
    logic [CLW-1:0] nb_col;
    logic [IW-1:0]  nb_addr, start_addr;
    logic [CLW-1:0] s_col, g_col;
    logic [31:0]    sq_bit, sq_try;
    logic [CSW-1:0] nd;
    logic           relax;
    logic [2*DW:0]  dx_w, dy_w;
    logic [2*DW:0]  sq_sum;
    logic [PW-1:0]  parent_p;
    t_node          init_node;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_load = (r_state == S_EMIT) && (!r_o_valid || !i_stall);
    assign start_in = int'(i_start_cell) < CELLS;
    assign goal_in  = int'(i_goal_cell) < CELLS;
    assign cell_in  = int'(i_cell_index) < CELLS;
    assign s_col    = CLW'(r_sidx);
    assign g_col    = CLW'(r_gidx);
    assign start_addr = addr_of(r_srow, s_col);

    assign init_node = '{is_open: 1'b0, is_closed: 1'b0, parent: '0,
                         score: gas_pkg::COST_INF, cost: gas_pkg::COST_INF};

    always_comb begin
        unique case (r_k)
            3'd0:    begin nb_dr = gas_pkg::OFS_MINUS; nb_dc = gas_pkg::OFS_MINUS; end
            3'd1:    begin nb_dr = gas_pkg::OFS_MINUS; nb_dc = gas_pkg::OFS_ZERO;  end
            3'd2:    begin nb_dr = gas_pkg::OFS_MINUS; nb_dc = gas_pkg::OFS_PLUS;  end
            3'd3:    begin nb_dr = gas_pkg::OFS_ZERO;  nb_dc = gas_pkg::OFS_MINUS; end
            3'd4:    begin nb_dr = gas_pkg::OFS_ZERO;  nb_dc = gas_pkg::OFS_PLUS;  end
            3'd5:    begin nb_dr = gas_pkg::OFS_PLUS;  nb_dc = gas_pkg::OFS_MINUS; end
            3'd6:    begin nb_dr = gas_pkg::OFS_PLUS;  nb_dc = gas_pkg::OFS_ZERO;  end
            default: begin nb_dr = gas_pkg::OFS_PLUS;  nb_dc = gas_pkg::OFS_PLUS;  end
        endcase
    end

    assign nb_in = !(nb_dr == gas_pkg::OFS_MINUS && r_brow == '0)
                && !(nb_dr == gas_pkg::OFS_PLUS && r_brow == RW'(GRID_HEIGHT - 1))
                && !(nb_dc == gas_pkg::OFS_MINUS && r_bcol == '0)
                && !(nb_dc == gas_pkg::OFS_PLUS && r_bcol == CLW'(GRID_WIDTH - 1));
    assign nb_row = (nb_dr == gas_pkg::OFS_MINUS) ? r_brow - RW'(1) :
                    (nb_dr == gas_pkg::OFS_PLUS)  ? r_brow + RW'(1) : r_brow;
    assign nb_col = (nb_dc == gas_pkg::OFS_MINUS) ? r_bcol - CLW'(1) :
                    (nb_dc == gas_pkg::OFS_PLUS)  ? r_bcol + CLW'(1) : r_bcol;
    assign nb_diag = (nb_dr != gas_pkg::OFS_ZERO) && (nb_dc != gas_pkg::OFS_ZERO);
    assign nb_addr = addr_of(nb_row, nb_col);

    assign sq_bit = 32'd1 << {r_sq_k, 1'b0};
    assign sq_try = r_sq_res + sq_bit;
    assign dx_w   = (2*DW+1)'(r_dx);
    assign dy_w   = (2*DW+1)'(r_dy);
    assign sq_sum = dx_w * dx_w + dy_w * dy_w;

    assign nd = gas_pkg::sat_add(r_best.cost,
                    r_diag ? gas_pkg::STEP_DIAG : gas_pkg::STEP_STRAIGHT);
    assign relax = nd < sm_rdata.cost;
    assign parent_p = sm_rdata.parent;

    always_comb begin
        n_nw = sm_rdata;
        n_nw.is_open = sm_rdata.is_open | !sm_rdata.is_closed;
        if (relax) begin
            n_nw.parent = {r_brow, r_bcol};
            n_nw.cost   = nd;
        end
    end

    // RAM port control
    always_comb begin
        obs_we    = 1'b0;
        obs_waddr = r_cnt;
        obs_wdata = 1'b0;
        obs_raddr = start_addr;
        sm_we     = 1'b0;
        sm_waddr  = r_cnt;
        sm_wdata  = init_node;
        sm_raddr  = r_cnt;
        pth_we    = 1'b0;
        pth_waddr = IW'(r_len);
        pth_wdata = parent_p;
        pth_raddr = IW'(r_pc - CW'(1) - r_rp);
        unique case (r_state)
            S_INIT: begin
                obs_we = 1'b1;
            end
            S_IDLE: begin
                obs_we    = accept && (i_mode == gas_pkg::MODE_WRITE) && cell_in;
                obs_waddr = IW'(i_cell_index);
                obs_wdata = i_blocked;
            end
            S_CLR: begin
                sm_we = 1'b1;
            end
            S_SEED: begin
                sm_we    = 1'b1;
                sm_waddr = start_addr;
                sm_wdata = '{is_open: 1'b1, is_closed: 1'b0, parent: '0,
                             score: r_sq_res[CSW-1:0], cost: '0};
            end
            S_PICK: begin
                sm_we    = r_have;
                sm_waddr = r_baddr;
                sm_wdata = r_best;
                sm_wdata.is_open   = 1'b0;
                sm_wdata.is_closed = 1'b1;
                pth_we    = r_have && (r_brow == r_grow) && (r_bcol == g_col);
                pth_waddr = '0;
                pth_wdata = {r_grow, g_col};
            end
            S_NB: begin
                obs_raddr = nb_addr;
                sm_raddr  = nb_addr;
            end
            S_NBWR: begin
                sm_we    = 1'b1;
                sm_waddr = r_naddr;
                sm_wdata = r_nw;
                if (r_upd) begin
                    sm_wdata.score = gas_pkg::sat_add(r_nw.cost, r_sq_res[CSW-1:0]);
                end
            end
            S_TB: begin
                sm_raddr = addr_of(r_cur_row, r_cur_col);
            end
            S_TBRD: begin
                pth_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= '0;
            r_pc      <= '0;
            r_rp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == IW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_res_status <= gas_pkg::ST_OK;
                        r_res_len    <= '0;
                        r_res_col    <= '0;
                        r_res_row    <= '0;
                        r_res_last   <= 1'b0;
                        r_state      <= S_EMIT;
                        case (i_mode)
                            gas_pkg::MODE_SEARCH: begin
                                r_pc   <= '0;
                                r_rp   <= '0;
                                r_sidx <= i_start_cell;
                                r_gidx <= i_goal_cell;
                                r_srow <= '0;
                                r_grow <= '0;
                                if (start_in && goal_in) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_res_status <= gas_pkg::ST_NO_PATH;
                                end
                            end
                            gas_pkg::MODE_READ: begin
                                if (r_rp < r_pc) begin
                                    r_state <= S_PRD;
                                end else begin
                                    r_res_status <= gas_pkg::ST_PAST;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (int'(r_sidx) >= GRID_WIDTH) begin
                        r_sidx <= r_sidx - 8'(GRID_WIDTH);
                        r_srow <= r_srow + RW'(1);
                    end
                    if (int'(r_gidx) >= GRID_WIDTH) begin
                        r_gidx <= r_gidx - 8'(GRID_WIDTH);
                        r_grow <= r_grow + RW'(1);
                    end
                    if (int'(r_sidx) < GRID_WIDTH && int'(r_gidx) < GRID_WIDTH) begin
                        r_cnt   <= '0;
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == IW'(CELLS - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (obs_rdata) begin
                        r_res_status <= gas_pkg::ST_NO_PATH;
                        r_state      <= S_EMIT;
                    end else begin
                        r_dx     <= abs_diff(DW'(s_col), DW'(g_col));
                        r_dy     <= abs_diff(DW'(r_srow), DW'(r_grow));
                        r_sq_ret <= S_SEED;
                        r_state  <= S_SQL;
                    end
                end
                S_SQL: begin
                    r_sq_v   <= 32'(sq_sum) << 16;
                    r_sq_res <= '0;
                    r_sq_k   <= 4'd15;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    if (r_sq_v >= sq_try) begin
                        r_sq_v   <= r_sq_v - sq_try;
                        r_sq_res <= (r_sq_res >> 1) + sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_k <= r_sq_k - 4'd1;
                    if (r_sq_k == 4'd0) begin
                        r_state <= r_sq_ret;
                    end
                end
                S_SEED, S_NEXT: begin
                    if (r_state == S_NEXT && r_k != 3'd7) begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NB;
                    end else begin
                        r_cnt   <= '0;
                        r_crow  <= '0;
                        r_ccol  <= '0;
                        r_pv    <= 1'b0;
                        r_sdone <= 1'b0;
                        r_have  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv <= !r_sdone;
                    if (!r_sdone) begin
                        r_pidx <= r_cnt;
                        r_prow <= r_crow;
                        r_pcol <= r_ccol;
                        r_cnt  <= r_cnt + IW'(1);
                        if (r_ccol == CLW'(GRID_WIDTH - 1)) begin
                            r_ccol <= '0;
                            r_crow <= r_crow + RW'(1);
                        end else begin
                            r_ccol <= r_ccol + CLW'(1);
                        end
                        if (r_cnt == IW'(CELLS - 1)) begin
                            r_sdone <= 1'b1;
                        end
                    end
                    if (r_pv && sm_rdata.is_open && !sm_rdata.is_closed
                            && (!r_have || sm_rdata.score < r_best.score)) begin
                        r_have  <= 1'b1;
                        r_best  <= sm_rdata;
                        r_baddr <= r_pidx;
                        r_brow  <= r_prow;
                        r_bcol  <= r_pcol;
                    end
                    if (r_sdone && !r_pv) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (!r_have) begin
                        r_res_status <= gas_pkg::ST_NO_PATH;
                        r_state      <= S_EMIT;
                    end else if (r_brow == r_grow && r_bcol == g_col) begin
                        r_len     <= CW'(1);
                        r_cur_row <= r_grow;
                        r_cur_col <= g_col;
                        r_state   <= S_TB;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_NB;
                    end
                end
                S_NB: begin
                    r_nrow  <= nb_row;
                    r_ncol  <= nb_col;
                    r_naddr <= nb_addr;
                    r_diag  <= nb_diag;
                    r_state <= nb_in ? S_NBCHK : S_NEXT;
                end
                S_NBCHK: begin
                    if (obs_rdata) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_nw  <= n_nw;
                        r_upd <= relax;
                        if (relax) begin
                            r_dx     <= abs_diff(DW'(r_ncol), DW'(g_col));
                            r_dy     <= abs_diff(DW'(r_nrow), DW'(r_grow));
                            r_sq_ret <= S_NBWR;
                            r_state  <= S_SQL;
                        end else begin
                            r_state <= S_NBWR;
                        end
                    end
                end
                S_NBWR: begin
                    r_state <= S_NEXT;
                end
                S_TB: begin
                    if (r_cur_row == r_srow && r_cur_col == s_col) begin
                        r_pc         <= r_len;
                        r_res_status <= gas_pkg::ST_OK;
                        r_res_len    <= (int'(r_len) > gas_pkg::PLEN_MAX) ?
                                        9'(gas_pkg::PLEN_MAX) : 9'(r_len);
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_TBRD;
                    end
                end
                S_TBRD: begin
                    r_cur_row <= parent_p[PW-1:CLW];
                    r_cur_col <= parent_p[CLW-1:0];
                    r_len     <= r_len + CW'(1);
                    r_state   <= S_TB;
                end
                S_PRD: begin
                    r_res_col  <= 4'(pth_rdata[CLW-1:0]);
                    r_res_row  <= 4'(pth_rdata[PW-1:CLW]);
                    r_res_last <= (r_rp + CW'(1) == r_pc);
                    r_rp       <= r_rp + CW'(1);
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_o_status <= r_res_status;
                        r_o_len    <= r_res_len;
                        r_o_col    <= r_res_col;
                        r_o_row    <= r_res_row;
                        r_o_last   <= r_res_last;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
        .i_clk   (i_clk),
        .i_we    (obs_we),
        .i_waddr (obs_waddr),
        .i_wdata (obs_wdata),
        .i_raddr (obs_raddr),
        .o_rdata (obs_rdata)
    );

    gas_ram #(.WIDTH($bits(t_node)), .DEPTH(CELLS)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    gas_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (pth_we),
        .i_waddr (pth_waddr),
        .i_wdata (pth_wdata),
        .i_raddr (pth_raddr),
        .o_rdata (pth_rdata)
    );

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_path_length = r_o_len;
    assign o_cell_column = r_o_col;
    assign o_cell_row    = r_o_row;
    assign o_last_cell   = r_o_last;

    a_rp_le_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_pc)
        else $error("read pointer beyond path count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word left no work");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_o_valid) |=> r_o_valid && (r_state == S_IDLE))
        else $error("pending result not moved to output register");

endmodule

[src/gas_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
